@@ hw/rtl/upc_pkg.sv @@
// ----------------------------------------------------------------------------
// upc_pkg: shared types and constants of the URL percent codec
// Decode phases, register indexes, reset values and hex digit helpers.
// ----------------------------------------------------------------------------
package upc_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_ONE  = 2'd2,
        PH_DROP = 2'd3
    } t_phase;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_MAP0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_MAP1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_MAP2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_MAP3   = 3'd4;

    // Reset map: 0-9, A-Z, a-z and $-_.+!*'() are safe.
    localparam logic [63:0] SAFE_MAP0_RST = 64'd288071574030909440;
    localparam logic [63:0] SAFE_MAP1_RST = 64'd576460745995190270;
    localparam logic [63:0] SAFE_MAP2_RST = 64'd0;
    localparam logic [63:0] SAFE_MAP3_RST = 64'd0;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;

    // Everything one input word produces, handed from the step logic to the
    // result buffer and the escape state.
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic       last;
        logic       err;
        t_phase     phase;
        logic [3:0] nibble;
    } t_step_out;

    // Upper-case hex digit of a nibble.
    function automatic logic [7:0] hex_upper(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10) begin
            r = 8'(8'h30 + {4'h0, n});
        end else begin
            r = 8'(8'h37 + {4'h0, n});
        end
        return r;
    endfunction

    // Bit 4 set when the character is a hex digit of either case; bits 3:0 hold its value.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/url_percent_codec_top.sv @@
// ----------------------------------------------------------------------------
// url_percent_codec_top: URL percent encoder and decoder
// Byte stream in, byte stream out, with a register port for mode and safe map.
// ----------------------------------------------------------------------------
// Each input word is worked out in the cycle it is accepted and its results
// (up to three bytes) land in a three-entry result buffer that drains one
// word per cycle while the output is ready. A new input word is taken when
// the buffer is empty or its final entry leaves in the same cycle, so an
// unsafe byte in encode mode holds off the next input word until the output
// port has drained the '%' and two hex digits. Words that produce no result
// (the '%' and first digit of an escape, and bytes dropped after a malformed
// escape) leave the buffer empty. Errors come out as a word with tuser set,
// data zero and tlast set, closing the message.
// ----------------------------------------------------------------------------
module url_percent_codec_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [upc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] error
);

    logic            r_decode_mode;
    logic [63:0]     r_safe_map [4];
    upc_pkg::t_phase r_phase;
    logic [3:0]      r_nibble;
    logic [1:0]      r_cnt;
    logic [7:0]      r_buf [3];
    logic            r_last;
    logic            r_err;

    logic [1:0]      n_cnt;
    logic            in_fire;
    logic            out_fire;
    logic [255:0]    safe_map;
    upc_pkg::t_step_out step;

    assign safe_map = {r_safe_map[3], r_safe_map[2], r_safe_map[1], r_safe_map[0]};

    upc_step u_step (
        .i_byte        (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .i_decode_mode (r_decode_mode),
        .i_safe_map    (safe_map),
        .i_phase       (r_phase),
        .i_nibble      (r_nibble),
        .o_step        (step)
    );

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = r_buf[0];
    assign m_axis_tlast  = r_last && (r_cnt == 2'd1);
    assign m_axis_tuser  = r_err;
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && m_axis_tready);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_cnt = r_cnt;
        if (in_fire) begin
            n_cnt = step.count;
        end else if (out_fire) begin
            n_cnt = 2'(r_cnt - 2'd1);
        end
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_mode <= 1'b0;
            r_safe_map[0] <= upc_pkg::SAFE_MAP0_RST;
            r_safe_map[1] <= upc_pkg::SAFE_MAP1_RST;
            r_safe_map[2] <= upc_pkg::SAFE_MAP2_RST;
            r_safe_map[3] <= upc_pkg::SAFE_MAP3_RST;
            r_phase       <= upc_pkg::PH_IDLE;
            r_nibble      <= 4'd0;
            r_cnt         <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (in_fire) begin
                r_phase  <= step.phase;
                r_nibble <= step.nibble;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    upc_pkg::REG_DECODE_MODE: r_decode_mode <= i_cfg_data[0];
                    upc_pkg::REG_SAFE_MAP0:   r_safe_map[0] <= i_cfg_data;
                    upc_pkg::REG_SAFE_MAP1:   r_safe_map[1] <= i_cfg_data;
                    upc_pkg::REG_SAFE_MAP2:   r_safe_map[2] <= i_cfg_data;
                    upc_pkg::REG_SAFE_MAP3:   r_safe_map[3] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result buffer: loaded whole on accept, shifted toward the head on drain.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_buf[0] <= step.byte0;
            r_buf[1] <= step.byte1;
            r_buf[2] <= step.byte2;
            r_last   <= step.last;
            r_err    <= step.err;
        end else if (out_fire) begin
            r_buf[0] <= r_buf[1];
            r_buf[1] <= r_buf[2];
        end
    end

    // An error word always closes its message.
    a_err_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == 8'd0)))
        else $error("error word without tlast or with nonzero data");

    // Encode mode never leaves a decode escape pending.
    a_encode_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !r_decode_mode) |=> (r_phase == upc_pkg::PH_IDLE && r_nibble == 4'd0))
        else $error("decode phase left pending by encode step");

    // A stalled buffer keeps its head word.
    a_hold_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result word changed while stalled");

endmodule

@@ hw/rtl/upc_step.sv @@
// ----------------------------------------------------------------------------
// upc_step: per-word encode and decode logic
// Works out the results of one input word and the next decode phase.
// ----------------------------------------------------------------------------
module upc_step (
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    input  logic            i_decode_mode,
    input  logic [255:0]    i_safe_map,
    input  upc_pkg::t_phase i_phase,
    input  logic [3:0]      i_nibble,
    output upc_pkg::t_step_out o_step
);

    logic [4:0] hex;

    assign hex = upc_pkg::hex_value(i_byte);

    always_comb begin
        o_step        = '0;
        o_step.phase  = i_phase;
        o_step.nibble = i_nibble;
        if (!i_decode_mode) begin
            // Encoding drops any half-finished escape.
            o_step.phase  = upc_pkg::PH_IDLE;
            o_step.nibble = 4'd0;
            if (i_safe_map[i_byte]) begin
                o_step.count = 2'd1;
                o_step.byte0 = i_byte;
                o_step.last  = i_last;
            end else begin
                o_step.count = 2'd3;
                o_step.byte0 = upc_pkg::CHAR_PERCENT;
                o_step.byte1 = upc_pkg::hex_upper(i_byte[7:4]);
                o_step.byte2 = upc_pkg::hex_upper(i_byte[3:0]);
                o_step.last  = i_last;
            end
        end else begin
            unique case (i_phase)
                upc_pkg::PH_IDLE: begin
                    if (i_byte == upc_pkg::CHAR_PERCENT) begin
                        if (i_last) begin
                            o_step.count = 2'd1;
                            o_step.last  = 1'b1;
                            o_step.err   = 1'b1;
                        end else begin
                            o_step.phase = upc_pkg::PH_PCT;
                        end
                    end else begin
                        o_step.count = 2'd1;
                        o_step.byte0 = i_byte;
                        o_step.last  = i_last;
                    end
                end
                upc_pkg::PH_PCT: begin
                    if (!hex[4] || i_last) begin
                        o_step.phase  = i_last ? upc_pkg::PH_IDLE : upc_pkg::PH_DROP;
                        o_step.nibble = 4'd0;
                        o_step.count  = 2'd1;
                        o_step.last   = 1'b1;
                        o_step.err    = 1'b1;
                    end else begin
                        o_step.nibble = hex[3:0];
                        o_step.phase  = upc_pkg::PH_ONE;
                    end
                end
                upc_pkg::PH_ONE: begin
                    o_step.nibble = 4'd0;
                    o_step.count  = 2'd1;
                    if (!hex[4]) begin
                        o_step.phase = i_last ? upc_pkg::PH_IDLE : upc_pkg::PH_DROP;
                        o_step.last  = 1'b1;
                        o_step.err   = 1'b1;
                    end else begin
                        o_step.phase = upc_pkg::PH_IDLE;
                        o_step.byte0 = {i_nibble, hex[3:0]};
                        o_step.last  = i_last;
                    end
                end
                upc_pkg::PH_DROP: begin
                    if (i_last) begin
                        o_step.phase = upc_pkg::PH_IDLE;
                    end
                    o_step.nibble = 4'd0;
                end
                default: begin
                    o_step.phase = upc_pkg::PH_IDLE;
                end
            endcase
        end
    end

endmodule

@@ bench/url_percent_codec_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_codec_top_test: self-checking bench for the URL percent codec
// Drives byte streams through both encode and decode modes under several safe
// maps, predicts every output word with an in-bench model of the codec and
// compares each accepted word field by field, with random stalls on both
// stream ports.
// ----------------------------------------------------------------------------
module url_percent_codec_top_test;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
        logic       err;
    } t_codec_word;

    // Tracks the codec's mode, safe map and escape state, and holds the
    // output words that accepted input bytes still owe.
    class escape_scoreboard;
        logic            decode_en;
        logic [63:0]     safe_map [4];
        upc_pkg::t_phase phase;
        logic [3:0]      nibble;
        t_codec_word     owed_words [$];
        int unsigned     mismatches;

        function new();
            decode_en   = 1'b0;
            safe_map[0] = upc_pkg::SAFE_MAP0_RST;
            safe_map[1] = upc_pkg::SAFE_MAP1_RST;
            safe_map[2] = upc_pkg::SAFE_MAP2_RST;
            safe_map[3] = upc_pkg::SAFE_MAP3_RST;
            phase       = upc_pkg::PH_IDLE;
            nibble      = 4'h0;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [upc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
            unique case (idx)
                upc_pkg::REG_DECODE_MODE: decode_en = val[0];
                upc_pkg::REG_SAFE_MAP0:   safe_map[0] = val;
                upc_pkg::REG_SAFE_MAP1:   safe_map[1] = val;
                upc_pkg::REG_SAFE_MAP2:   safe_map[2] = val;
                upc_pkg::REG_SAFE_MAP3:   safe_map[3] = val;
                default: ;
            endcase
        endfunction

        function logic [7:0] digit_char(logic [3:0] n);
            logic [7:0] c;
            if (n < 4'd10) begin
                c = 8'h30 + 8'(n);
            end else begin
                c = 8'h41 + 8'(n) - 8'd10;
            end
            return c;
        endfunction

        // Bit 4 flags a hex digit of either case, bits 3:0 carry its value.
        function logic [4:0] hex_lookup(logic [7:0] c);
            logic [4:0] r;
            r = 5'd0;
            if (c >= "0" && c <= "9") r = {1'b1, 4'(c - 8'h30)};
            if (c >= "A" && c <= "F") r = {1'b1, 4'(c - 8'h41 + 8'd10)};
            if (c >= "a" && c <= "f") r = {1'b1, 4'(c - 8'h61 + 8'd10)};
            return r;
        endfunction

        function void owe(logic [7:0] data, logic is_last, logic err);
            t_codec_word w;
            w.data    = data;
            w.is_last = is_last;
            w.err     = err;
            owed_words.push_back(w);
        endfunction

        function void abort_escape(logic is_last);
            phase  = is_last ? upc_pkg::PH_IDLE : upc_pkg::PH_DROP;
            nibble = 4'h0;
            owe(8'h00, 1'b1, 1'b1);
        endfunction

        function void take_input(logic [7:0] b, logic is_last);
            logic [4:0] hv;
            hv = hex_lookup(b);
            if (!decode_en) begin
                phase  = upc_pkg::PH_IDLE;
                nibble = 4'h0;
                if (safe_map[b[7:6]][b[5:0]]) begin
                    owe(b, is_last, 1'b0);
                end else begin
                    owe(upc_pkg::CHAR_PERCENT, 1'b0, 1'b0);
                    owe(digit_char(b[7:4]), 1'b0, 1'b0);
                    owe(digit_char(b[3:0]), is_last, 1'b0);
                end
            end else begin
                unique case (phase)
                    upc_pkg::PH_IDLE: begin
                        if (b != upc_pkg::CHAR_PERCENT) begin
                            owe(b, is_last, 1'b0);
                        end else if (is_last) begin
                            owe(8'h00, 1'b1, 1'b1);
                        end else begin
                            phase = upc_pkg::PH_PCT;
                        end
                    end
                    upc_pkg::PH_PCT: begin
                        // A single digit that ends the message is malformed too.
                        if (!hv[4] || is_last) begin
                            abort_escape(is_last);
                        end else begin
                            nibble = hv[3:0];
                            phase  = upc_pkg::PH_ONE;
                        end
                    end
                    upc_pkg::PH_ONE: begin
                        if (!hv[4]) begin
                            abort_escape(is_last);
                        end else begin
                            owe({nibble, hv[3:0]}, is_last, 1'b0);
                            phase  = upc_pkg::PH_IDLE;
                            nibble = 4'h0;
                        end
                    end
                    default: begin
                        if (is_last) phase = upc_pkg::PH_IDLE;
                        nibble = 4'h0;
                    end
                endcase
            end
        endfunction

        function void check_output(logic [7:0] data, logic is_last, logic err);
            t_codec_word w;
            if (owed_words.size() == 0) begin
                $error("unexpected output word: out_byte 8'h%02h out_last %0d error %0d",
                       data, is_last, err);
                mismatches++;
            end else begin
                w = owed_words.pop_front();
                if (data !== w.data) begin
                    $error("out_byte: expected 8'h%02h, got 8'h%02h", w.data, data);
                    mismatches++;
                end
                if (is_last !== w.is_last) begin
                    $error("out_last: expected %0d, got %0d", w.is_last, is_last);
                    mismatches++;
                end
                if (err !== w.err) begin
                    $error("error: expected %0d, got %0d", w.err, err);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [upc_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0]                   i_cfg_data = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata = 8'h00;
    logic                          s_axis_tlast = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [7:0]                    m_axis_tdata;
    logic                          m_axis_tlast;
    logic                          m_axis_tuser;

    escape_scoreboard sb = new();
    bit               no_gaps = 1'b0;
    int unsigned      out_stall = 0;

    url_percent_codec_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        int unsigned g;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            g = 0;
        end else if (r < 93) begin
            g = $urandom_range(1, 3);
        end else begin
            g = $urandom_range(8, 30);
        end
        return g;
    endfunction

    always @(negedge i_clk) begin
        if (no_gaps) begin
            m_axis_tready = 1'b1;
            out_stall = 0;
        end else if (out_stall != 0) begin
            m_axis_tready = 1'b0;
            out_stall--;
        end else begin
            m_axis_tready = 1'b1;
            out_stall = pick_gap();
        end
    end

    // Inputs are noted before outputs are checked, on each rising clock edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.take_input(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_output(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic is_last);
        int unsigned gap;
        gap = no_gaps ? 0 : pick_gap();
        @(negedge i_clk);
        repeat (gap) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tlast  = is_last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drops the input valid and waits until every owed word has come out.
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.owed_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [upc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_map(input logic [63:0] w0, input logic [63:0] w1,
                             input logic [63:0] w2, input logic [63:0] w3);
        write_reg(upc_pkg::REG_SAFE_MAP0, w0);
        write_reg(upc_pkg::REG_SAFE_MAP1, w1);
        write_reg(upc_pkg::REG_SAFE_MAP2, w2);
        write_reg(upc_pkg::REG_SAFE_MAP3, w3);
    endtask

    function automatic logic [7:0] rand_hex_char();
        logic [3:0] v;
        logic [7:0] c;
        v = 4'($urandom_range(0, 15));
        if (v < 4'd10) begin
            c = 8'h30 + 8'(v);
        end else if ($urandom_range(0, 1) == 0) begin
            c = 8'h41 + 8'(v) - 8'd10;
        end else begin
            c = 8'h61 + 8'(v) - 8'd10;
        end
        return c;
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        logic [4:0] hv;
        do begin
            c  = 8'($urandom_range(0, 255));
            hv = sb.hex_lookup(c);
        end while (hv[4]);
        return c;
    endfunction

    function automatic logic [7:0] rand_plain();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == upc_pkg::CHAR_PERCENT);
        return c;
    endfunction

    task automatic run_encode(input int unsigned n);
        logic [7:0] b;
        repeat (n) begin
            if ($urandom_range(0, 1) == 0) begin
                b = 8'($urandom_range(0, 255));
            end else begin
                b = 8'($urandom_range(8'h20, 8'h7e));
            end
            send_word(b, $urandom_range(0, 5) == 0);
        end
    endtask

    // Mostly well-formed messages of plain bytes and escapes, with some
    // malformed escapes (rest of the message dropped) and some messages cut
    // off in the middle of an escape.
    task automatic run_decode(input int unsigned n);
        logic [7:0]  msg [$];
        int unsigned sent;
        int unsigned tokens;
        int unsigned r;
        bit          cut;
        sent = 0;
        while (sent < n) begin
            msg.delete();
            cut = 1'b0;
            tokens = $urandom_range(1, 6);
            for (int t = 0; t < tokens && !cut; t++) begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    msg.push_back(rand_plain());
                end else if (r < 82) begin
                    msg.push_back(upc_pkg::CHAR_PERCENT);
                    msg.push_back(rand_hex_char());
                    msg.push_back(rand_hex_char());
                end else if (r < 88) begin
                    msg.push_back(upc_pkg::CHAR_PERCENT);
                    msg.push_back(rand_non_hex());
                end else if (r < 94) begin
                    msg.push_back(upc_pkg::CHAR_PERCENT);
                    msg.push_back(rand_hex_char());
                    msg.push_back(rand_non_hex());
                end else begin
                    msg.push_back(upc_pkg::CHAR_PERCENT);
                    if ($urandom_range(0, 1) == 0) msg.push_back(rand_hex_char());
                    cut = 1'b1;
                end
            end
            foreach (msg[i]) send_word(msg[i], i == msg.size() - 1);
            sent += msg.size();
        end
    endtask

    initial begin
        #2_000_000;
        $display("url_percent_codec_top_test: done, errors");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Encode with the reset map: safe, unsafe, both byte extremes.
        send_word("A", 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hff, 1'b1);
        send_word(" ", 1'b0);
        send_word("~", 1'b0);
        send_word(upc_pkg::CHAR_PERCENT, 1'b1);
        wait_idle();

        write_reg(upc_pkg::REG_DECODE_MODE, 64'd1);
        // Two escapes, one with a lower-case digit, then a lone percent closing a message.
        send_word(upc_pkg::CHAR_PERCENT, 1'b0);
        send_word("4", 1'b0);
        send_word("1", 1'b0);
        send_word("x", 1'b0);
        send_word(upc_pkg::CHAR_PERCENT, 1'b0);
        send_word("6", 1'b0);
        send_word("f", 1'b1);
        send_word(upc_pkg::CHAR_PERCENT, 1'b1);
        // One digit carrying the end of the message.
        send_word(upc_pkg::CHAR_PERCENT, 1'b0);
        send_word("A", 1'b1);
        // Non-hex after the percent, then bytes that must be dropped.
        send_word(upc_pkg::CHAR_PERCENT, 1'b0);
        send_word("G", 1'b0);
        send_word("q", 1'b0);
        send_word(upc_pkg::CHAR_PERCENT, 1'b1);
        // Bad second digit on the final byte.
        send_word(upc_pkg::CHAR_PERCENT, 1'b0);
        send_word("4", 1'b0);
        send_word("Z", 1'b1);
        // Leave an escape half done, then encode a byte, which clears it.
        send_word(upc_pkg::CHAR_PERCENT, 1'b0);
        send_word("4", 1'b0);
        wait_idle();
        write_reg(upc_pkg::REG_DECODE_MODE, 64'd0);
        send_word("B", 1'b1);
        wait_idle();
        write_reg(upc_pkg::REG_DECODE_MODE, 64'd1);
        send_word("1", 1'b1);
        wait_idle();

        no_gaps = ($urandom_range(0, 3) == 0);
        write_reg(upc_pkg::REG_DECODE_MODE, 64'd0);
        write_map(64'd0, 64'd0, 64'd0, 64'd0);
        run_encode(38);
        wait_idle();

        no_gaps = ($urandom_range(0, 3) == 0);
        write_map('1, '1, '1, '1);
        run_encode(38);
        wait_idle();

        no_gaps = ($urandom_range(0, 3) == 0);
        write_reg(upc_pkg::REG_DECODE_MODE, 64'd1);
        run_decode(40);
        wait_idle();

        no_gaps = ($urandom_range(0, 3) == 0);
        write_reg(upc_pkg::REG_DECODE_MODE, {$urandom, $urandom} & ~64'd1);
        write_map({$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
        run_encode(40);
        wait_idle();

        no_gaps = 1'b0;
        write_reg(upc_pkg::REG_DECODE_MODE, {$urandom, $urandom} | 64'd1);
        run_decode(40);
        wait_idle();

        // Indexes past the register list must leave everything alone.
        no_gaps = ($urandom_range(0, 3) == 0);
        for (int i = int'(upc_pkg::REG_SAFE_MAP3) + 1; i < (1 << upc_pkg::CFG_IDX_W);
             i++) begin
            write_reg(i[upc_pkg::CFG_IDX_W-1:0], {$urandom, $urandom});
        end
        write_reg(upc_pkg::REG_DECODE_MODE, 64'd0);
        write_map(upc_pkg::SAFE_MAP0_RST, upc_pkg::SAFE_MAP1_RST,
                  upc_pkg::SAFE_MAP2_RST, upc_pkg::SAFE_MAP3_RST);
        run_encode(40);
        wait_idle();

        no_gaps = 1'b1;
        write_reg(upc_pkg::REG_DECODE_MODE, 64'd1);
        run_decode(30);
        wait_idle();

        no_gaps = 1'b0;
        run_decode(30);
        wait_idle();

        repeat (16) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.owed_words.size() == 0) begin
            $display("url_percent_codec_top_test: done, clean");
        end else begin
            $display("url_percent_codec_top_test: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/upc_pkg.sv
hw/rtl/upc_step.sv
hw/rtl/url_percent_codec_top.sv
bench/url_percent_codec_top_test.sv
